### src/kca_pkg.sv
// ---------------------------------------------------------------------------
// kca_pkg
// Shared types, register indexes and command codes for the kicker charge
// arbiter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package kca_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_KICK_PRESS      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_CHARGE_PRESS    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_DISCHARGE_PRESS = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_OVERRIDE        = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SAMPLE_PERIOD   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_MISMATCH_LIMIT  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_KICK_STRENGTH   = 3'd6;

  localparam logic [1:0] CMD_NONE      = 2'd0;
  localparam logic [1:0] CMD_CHARGE    = 2'd1;
  localparam logic [1:0] CMD_DISCHARGE = 2'd2;
  localparam logic [1:0] CMD_KICK      = 2'd3;

  localparam logic [9:0] TIMER_MAX = 10'd1023;
  localparam logic [6:0] POWER_MAX = 7'd100;

  localparam logic [15:0] KICK_PRESS_RST      = 16'd200;
  localparam logic [15:0] CHARGE_PRESS_RST    = 16'd800;
  localparam logic [15:0] DISCHARGE_PRESS_RST = 16'd1600;
  localparam logic [13:0] OVERRIDE_RST        = 14'd15000;
  localparam logic [9:0]  SAMPLE_PERIOD_RST   = 10'd100;
  localparam logic [7:0]  MISMATCH_LIMIT_RST  = 8'd10;
  localparam logic [6:0]  KICK_STRENGTH_RST   = 7'd50;

  typedef struct packed {
    logic        button_released;
    logic [15:0] press_duration_ms;
    logic        ui_activity;
    logic        charge_requested;
    logic        charger_active;
  } kca_in_t;

  typedef struct packed {
    logic [1:0] command;
    logic [6:0] kick_power;
    logic       led_write;
    logic       led_on;
  } kca_out_t;

  typedef struct packed {
    logic [15:0] kick_press_ms;
    logic [15:0] charge_press_ms;
    logic [15:0] discharge_press_ms;
    logic [13:0] override_ms;
    logic [9:0]  sample_period_ms;
    logic [7:0]  mismatch_limit;
    logic [6:0]  kick_strength;
  } kca_cfg_t;

endpackage

### src/kca_cfg_regs.sv
// ---------------------------------------------------------------------------
// kca_cfg_regs
// Configuration register file; writes beyond the last index are dropped.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module kca_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [kca_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [kca_pkg::CfgDataW-1:0] cfg_data,
  output kca_pkg::kca_cfg_t            cfg
);
  import kca_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kick_press_ms      <= KICK_PRESS_RST;
      cfg.charge_press_ms    <= CHARGE_PRESS_RST;
      cfg.discharge_press_ms <= DISCHARGE_PRESS_RST;
      cfg.override_ms        <= OVERRIDE_RST;
      cfg.sample_period_ms   <= SAMPLE_PERIOD_RST;
      cfg.mismatch_limit     <= MISMATCH_LIMIT_RST;
      cfg.kick_strength      <= KICK_STRENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KICK_PRESS:      cfg.kick_press_ms      <= cfg_data;
        REG_CHARGE_PRESS:    cfg.charge_press_ms    <= cfg_data;
        REG_DISCHARGE_PRESS: cfg.discharge_press_ms <= cfg_data;
        REG_OVERRIDE:        cfg.override_ms        <= cfg_data[13:0];
        REG_SAMPLE_PERIOD:   cfg.sample_period_ms   <= cfg_data[9:0];
        REG_MISMATCH_LIMIT:  cfg.mismatch_limit     <= cfg_data[7:0];
        REG_KICK_STRENGTH:   cfg.kick_strength      <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

endmodule

### src/kca_core.sv
// ---------------------------------------------------------------------------
// kca_core
// Per-tick arbitration: timers, button action and host mismatch checks,
// feeding a result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module kca_core (
  input  logic              clk,
  input  logic              rst,
  input  kca_pkg::kca_cfg_t cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  kca_pkg::kca_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output kca_pkg::kca_out_t out_data
);
  import kca_pkg::*;

  logic [13:0] override_counter, override_counter_next;
  logic [9:0]  sample_timer, sample_timer_next;
  logic [7:0]  charge_mismatch_count, charge_mismatch_count_next;
  logic [7:0]  discharge_mismatch_count, discharge_mismatch_count_next;
  kca_out_t    result;
  logic        accept;
  logic [13:0] ovr_adv;
  logic [9:0]  tmr_adv;
  logic [7:0]  chg_inc, dis_inc;

  // result register frees up the same cycle it drains
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    ovr_adv = (override_counter >= cfg.override_ms) ? cfg.override_ms
                                                    : override_counter + 14'd1;
    tmr_adv = (sample_timer < TIMER_MAX) ? sample_timer + 10'd1 : sample_timer;
    chg_inc = charge_mismatch_count + 8'd1;
    dis_inc = discharge_mismatch_count + 8'd1;

    override_counter_next         = ovr_adv;
    sample_timer_next             = tmr_adv;
    charge_mismatch_count_next    = charge_mismatch_count;
    discharge_mismatch_count_next = discharge_mismatch_count;
    result                        = '0;
    result.command                = CMD_NONE;

    priority if (in_data.button_released) begin
      priority if (in_data.press_duration_ms > cfg.discharge_press_ms) begin
        result.command   = CMD_DISCHARGE;
        result.led_write = 1'b1;
      end else if (in_data.press_duration_ms > cfg.charge_press_ms) begin
        result.command   = CMD_CHARGE;
        result.led_write = 1'b1;
        result.led_on    = 1'b1;
      end else if (in_data.press_duration_ms > cfg.kick_press_ms) begin
        result.command    = CMD_KICK;
        result.kick_power = (cfg.kick_strength > POWER_MAX) ? POWER_MAX
                                                            : cfg.kick_strength;
      end else begin
        result.command = CMD_NONE;
      end
      override_counter_next = '0;
    end else if (in_data.ui_activity) begin
      override_counter_next = '0;
    end else if (ovr_adv >= cfg.override_ms && tmr_adv > cfg.sample_period_ms) begin
      if (in_data.charge_requested && !in_data.charger_active) begin
        if (chg_inc > cfg.mismatch_limit) begin
          result.command             = CMD_CHARGE;
          charge_mismatch_count_next = '0;
        end else begin
          charge_mismatch_count_next = chg_inc;
        end
      end else if (!in_data.charge_requested && in_data.charger_active) begin
        if (dis_inc > cfg.mismatch_limit) begin
          result.command                = CMD_DISCHARGE;
          discharge_mismatch_count_next = '0;
        end else begin
          discharge_mismatch_count_next = dis_inc;
        end
      end
      sample_timer_next = '0;
    end else begin
      result.command = CMD_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      override_counter         <= '0;
      sample_timer             <= '0;
      charge_mismatch_count    <= '0;
      discharge_mismatch_count <= '0;
      out_valid                <= 1'b0;
    end else begin
      if (accept) begin
        override_counter         <= override_counter_next;
        sample_timer             <= sample_timer_next;
        charge_mismatch_count    <= charge_mismatch_count_next;
        discharge_mismatch_count <= discharge_mismatch_count_next;
        out_valid                <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

`ifndef SYNTH
  a_led_cmd: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.led_write |->
      (out_data.command == CMD_CHARGE || out_data.command == CMD_DISCHARGE))
    else $error("led write without charge or discharge");

  a_power_kick: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.command != CMD_KICK |-> out_data.kick_power == 7'd0)
    else $error("kick power outside kick command");

  a_power_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.kick_power <= POWER_MAX)
    else $error("kick power above limit");

  a_release_clears: assert property (@(posedge clk) disable iff (rst)
    accept && (in_data.button_released || in_data.ui_activity) |=>
      override_counter == 14'd0)
    else $error("override counter not cleared by user action");

  a_stall_no_accept: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !accept)
    else $error("request accepted while result register is blocked");
`endif

endmodule

### src/kicker_charge_arbiter.sv
// ---------------------------------------------------------------------------
// kicker_charge_arbiter
// Button and host arbitration for the kicker charger, one request per tick.
// ---------------------------------------------------------------------------
// Output: a result is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle; the result register drains and refills
//   in the same cycle, so input stalls only while a held result is stalled.
// Reset: synchronous; clears all counters and timers, empties the result
//   register and loads the register defaults.
`timescale 1ns / 1ps

module kicker_charge_arbiter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  kca_pkg::kca_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output kca_pkg::kca_out_t            out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [kca_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [kca_pkg::CfgDataW-1:0] cfg_data
);
  import kca_pkg::*;

  kca_cfg_t cfg;

  kca_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kca_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
